// ----- rtl/tmwg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmwg_pkg;

  // payload widths
  localparam int unsigned AMP_W  = 12;
  localparam int unsigned DAC_W  = 12;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 7;

  // scale coefficient and product widths
  localparam int unsigned COEF_W = 13;
  localparam int unsigned PROD_W = AMP_W + COEF_W;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COEF_W-1:0] coef_t;

  // waveform codes
  localparam mode_t MODE_SQUARE = 2'd0;
  localparam mode_t MODE_SINE   = 2'd1;
  localparam mode_t MODE_SAW    = 2'd2;

  // period shapes
  localparam idx_t  SQ_LOW_LEN = 7'd24;
  localparam idx_t  SQ_LAST    = 7'd38;
  localparam idx_t  SAW_LAST   = 7'd39;
  localparam idx_t  SINE_RISE  = 7'd25;
  localparam idx_t  SINE_LAST  = 7'd72;
  localparam coef_t SAW_STEP   = 13'd119;
  localparam coef_t FULL_SCALE = 13'd4095;
  localparam logic [DAC_W-1:0] SINE_LEVEL = 12'd61;

  // positive half of the sine, scaled to dac counts
  function automatic coef_t sine_rom(input logic [4:0] k);
    coef_t v;
    unique case (k)
      5'd0:    v = 13'd0;
      5'd1:    v = 13'd485;
      5'd2:    v = 13'd963;
      5'd3:    v = 13'd1424;
      5'd4:    v = 13'd1861;
      5'd5:    v = 13'd2265;
      5'd6:    v = 13'd2631;
      5'd7:    v = 13'd2952;
      5'd8:    v = 13'd3223;
      5'd9:    v = 13'd3438;
      5'd10:   v = 13'd3595;
      5'd11:   v = 13'd3690;
      5'd12:   v = 13'd3722;
      5'd13:   v = 13'd3690;
      5'd14:   v = 13'd3595;
      5'd15:   v = 13'd3438;
      5'd16:   v = 13'd3223;
      5'd17:   v = 13'd2952;
      5'd18:   v = 13'd2631;
      5'd19:   v = 13'd2265;
      5'd20:   v = 13'd1861;
      5'd21:   v = 13'd1424;
      5'd22:   v = 13'd963;
      5'd23:   v = 13'd485;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tmwg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// input channel: sample ticks and button presses
interface tmwg_in_if
  import tmwg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             action;
  logic [AMP_W-1:0] amplitude;

  modport source (output valid, output action, output amplitude, input ready);
  modport sink   (input valid, input action, input amplitude, output ready);
endinterface

// output channel: one dac sample per tick
interface tmwg_out_if
  import tmwg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_code;
  mode_t            wave_mode;
  idx_t             sample_index;

  modport source (output valid, output dac_code, output wave_mode, output sample_index,
                  input ready);
  modport sink   (input valid, input dac_code, input wave_mode, input sample_index,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/three_mode_waveform_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Three-mode waveform generator. Each beat on in_i is either a sample tick (action 0),
// which yields exactly one dac sample on out_o, or a button press (action 1), which steps
// the selected mode square -> sine -> sawtooth -> square and yields nothing. A newly
// selected mode starts only when the running period ends. The block takes one beat per
// cycle when out_o keeps up; each tick's sample is registered in turn by a lookup stage
// (coefficient table), a 12x13 multiply stage and a stage that divides by 4095 with a
// shift and a two-step correction. Stalls on out_o back up through those three registers,
// and empty stages fill while the output waits.
module three_mode_waveform_generator
  import tmwg_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tmwg_in_if.sink     in_i,
  tmwg_out_if.source  out_o
);

  // sequencing state
  mode_t press_count_q, press_count_d;
  mode_t active_mode_q, active_mode_d;
  idx_t  phase_q, phase_d;

  // stage valids
  logic v1_q, v2_q, v3_q;
  logic rdy2, rdy3, in_rdy;
  logic in_fire, tick;

  // stage payloads
  mode_t               mode1_q, mode2_q, mode3_q;
  idx_t                k1_q, k2_q, k3_q;
  logic [AMP_W-1:0]    amp1_q;
  coef_t               coef1_q;
  logic                hold1_q, hold2_q;
  logic [PROD_W-1:0]   prod2_q;
  logic [DAC_W-1:0]    dac3_q;

  // accept-side signals
  mode_t mode_eff;
  idx_t  last_phase;
  coef_t coef;

  // divide-by-4095 signals
  logic [COEF_W-1:0] q0;
  logic [COEF_W:0]   rem;
  logic [COEF_W-1:0] quo;
  logic [DAC_W-1:0]  dac_d;

  // backpressure chain
  assign rdy3    = !v3_q || out_o.ready;
  assign rdy2    = !v2_q || rdy3;
  assign in_rdy  = !v1_q || rdy2;
  assign in_i.ready = in_rdy;
  assign in_fire = in_i.valid && in_rdy;
  assign tick    = in_fire && !in_i.action;

  // mode is latched at the start of a period
  assign mode_eff = (phase_q == '0) ? press_count_q : active_mode_q;

  // last phase of the running period
  always_comb begin
    unique case (mode_eff)
      MODE_SINE: last_phase = SINE_LAST;
      MODE_SAW:  last_phase = SAW_LAST;
      default:   last_phase = SQ_LAST;
    endcase
  end

  // scale coefficient for this phase
  always_comb begin
    unique case (mode_eff)
      MODE_SINE: coef = (phase_q < SINE_RISE) ? sine_rom(phase_q[4:0]) : '0;
      MODE_SAW:  coef = SAW_STEP * COEF_W'(phase_q);
      default:   coef = (phase_q < SQ_LOW_LEN) ? '0 : FULL_SCALE;
    endcase
  end

  // next state on presses and ticks
  always_comb begin
    press_count_d = press_count_q;
    active_mode_d = active_mode_q;
    phase_d       = phase_q;
    if (in_fire && in_i.action) begin
      press_count_d = (press_count_q == MODE_SAW) ? MODE_SQUARE : press_count_q + 2'd1;
    end else if (tick) begin
      active_mode_d = mode_eff;
      phase_d       = (phase_q == last_phase) ? '0 : phase_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q <= MODE_SQUARE;
      active_mode_q <= MODE_SQUARE;
      phase_q       <= '0;
    end else begin
      press_count_q <= press_count_d;
      active_mode_q <= active_mode_d;
      phase_q       <= phase_d;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_rdy) v1_q <= tick;
      if (rdy2)   v2_q <= v1_q;
      if (rdy3)   v3_q <= v2_q;
    end
  end

  // stage 1: lookup
  always_ff @(posedge clk_i) begin
    if (in_rdy && tick) begin
      mode1_q <= mode_eff;
      k1_q    <= phase_q;
      amp1_q  <= in_i.amplitude;
      coef1_q <= coef;
      hold1_q <= (mode_eff == MODE_SINE) && (phase_q >= SINE_RISE);
    end
  end

  // stage 2: multiply
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      mode2_q <= mode1_q;
      k2_q    <= k1_q;
      hold2_q <= hold1_q;
      prod2_q <= PROD_W'(amp1_q) * PROD_W'(coef1_q);
    end
  end

  // divide by 4095: x/4096 plus a correction of at most two
  assign q0  = prod2_q[PROD_W-1:AMP_W];
  assign rem = {2'b00, prod2_q[AMP_W-1:0]} + {1'b0, q0};
  assign quo = q0 + COEF_W'(rem >= (COEF_W+1)'(FULL_SCALE))
                  + COEF_W'(rem >= (COEF_W+1)'({FULL_SCALE, 1'b0}));
  assign dac_d = hold2_q ? SINE_LEVEL : quo[DAC_W-1:0];

  // stage 3: output register
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      mode3_q <= mode2_q;
      k3_q    <= k2_q;
      dac3_q  <= dac_d;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.dac_code     = dac3_q;
  assign out_o.wave_mode    = mode3_q;
  assign out_o.sample_index = k3_q;

  // press count stays in range
  a_press_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_count_q != 2'd3)
    else $error("press count out of range");

  // a press always steps the selection
  a_press_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action) |=> press_count_q != $past(press_count_q))
    else $error("press did not advance the mode count");

  // the active mode changes only at a period boundary
  a_mode_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(active_mode_q) |-> $past(phase_q) == '0)
    else $error("mode changed inside a period");

  // phase stays within the active period
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != '0) |-> ((active_mode_q == MODE_SINE && phase_q <= SINE_LAST) ||
                         (active_mode_q == MODE_SAW && phase_q <= SAW_LAST) ||
                         (active_mode_q == MODE_SQUARE && phase_q <= SQ_LAST)))
    else $error("phase beyond period");

endmodule

`default_nettype wire

// ----- tb/sv/three_mode_waveform_generator_tb.sv -----
`timescale 1ns / 1ps

module three_mode_waveform_generator_tb;
  import tmwg_pkg::*;

  // beat codes on the input channel
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_PRESS = 1'b1;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned RANDOM_BEATS = 1850;
  localparam int unsigned N_ROWS       = 20;

  // positive half of the sine in dac counts
  localparam int unsigned SINE_COEF [0:24] = '{
    0, 485, 963, 1424, 1861, 2265, 2631, 2952, 3223, 3438,
    3595, 3690, 3722, 3690, 3595, 3438, 3223, 2952, 2631, 2265,
    1861, 1424, 963, 485, 0
  };

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    mode_t            wave_mode;
    idx_t             sample_index;
  } dac_beat_t;

  typedef struct packed {
    logic             action;
    logic [AMP_W-1:0] amplitude;
    bit               typed;
    dac_beat_t        beat;
  } in_beat_t;

  typedef struct packed {
    logic             action;
    logic [AMP_W-1:0] amplitude;
    int unsigned      count;
    bit               typed;
    dac_beat_t        beat;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tmwg_in_if  in_ch ();
  tmwg_out_if out_ch ();

  three_mode_waveform_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // free running clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_beat_t    pending_beats [$];
  dac_beat_t   expected_samples [$];
  stim_row_t   directed_rows [N_ROWS];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned cycle_cnt      = 0;

  // generator state: mode picked by presses, mode of the running period, phase
  mode_t sel_mode  = MODE_SQUARE;
  mode_t run_mode  = MODE_SQUARE;
  idx_t  run_phase = '0;

  function automatic int unsigned period_len(input mode_t m);
    if (m == MODE_SINE) return SINE_LAST + 1;
    if (m == MODE_SAW)  return SAW_LAST + 1;
    return SQ_LAST + 1;
  endfunction

  // advance the generator by one accepted beat, give the sample it yields
  task automatic step_generator(input logic act, input logic [AMP_W-1:0] amp,
                                output bit produced, output dac_beat_t beat);
    int unsigned k;
    int unsigned value;
    produced = 1'b0;
    beat     = '0;
    if (act == ACT_PRESS) begin
      sel_mode = (sel_mode >= MODE_SAW) ? MODE_SQUARE : mode_t'(sel_mode + 1'b1);
    end else begin
      if (run_phase == 0) run_mode = sel_mode;
      if (run_mode > MODE_SAW) run_mode = MODE_SQUARE;
      k = run_phase;
      if (k >= period_len(run_mode)) k = 0;
      case (run_mode)
        MODE_SINE: begin
          value = (k < SINE_RISE) ? (amp * SINE_COEF[k]) / FULL_SCALE : SINE_LEVEL;
        end
        MODE_SAW: begin
          value = ((amp * (SAW_STEP * k)) / FULL_SCALE) & 32'hFFF;
        end
        default: begin
          value = (k < SQ_LOW_LEN) ? 0 : amp;
        end
      endcase
      beat.dac_code     = DAC_W'(value);
      beat.wave_mode    = run_mode;
      beat.sample_index = idx_t'(k);
      k = k + 1;
      if (k >= period_len(run_mode)) k = 0;
      run_phase = idx_t'(k);
      produced  = 1'b1;
    end
  endtask

  // input side: hold a beat until taken, then maybe idle, then offer the next
  always @(posedge clk) begin : drive_in
    bit        fired;
    bit        produced;
    dac_beat_t predicted;
    fired = in_ch.valid && in_ch.ready;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (fired) begin
        step_generator(in_ch.action, in_ch.amplitude, produced, predicted);
        if (produced) begin
          expected_samples.push_back(pending_beats[0].typed ? pending_beats[0].beat
                                                            : predicted);
        end
        void'(pending_beats.pop_front());
      end
      if (fired || !in_ch.valid) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.action    <= pending_beats[0].action;
          in_ch.amplitude <= pending_beats[0].amplitude;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output side: compare each sample with the oldest prediction
  always @(posedge clk) begin : check_out
    dac_beat_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual dac %0d mode %0d index %0d",
                 $time, out_ch.dac_code, out_ch.wave_mode, out_ch.sample_index);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.dac_code !== want.dac_code) begin
          $display("%0t: dac_code expected %0d actual %0d",
                   $time, want.dac_code, out_ch.dac_code);
          errors++;
        end
        if (out_ch.wave_mode !== want.wave_mode) begin
          $display("%0t: wave_mode expected %0d actual %0d",
                   $time, want.wave_mode, out_ch.wave_mode);
          errors++;
        end
        if (out_ch.sample_index !== want.sample_index) begin
          $display("%0t: sample_index expected %0d actual %0d",
                   $time, want.sample_index, out_ch.sample_index);
          errors++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("three_mode_waveform_generator: mismatch");
      $finish;
    end
  end

  // random beats: mostly tick runs of up to 80 beats, some press bursts of up to three
  task automatic queue_random_beats(input int unsigned n);
    int unsigned made;
    int unsigned run;
    int unsigned i;
    logic [AMP_W-1:0] amp;
    in_beat_t b;
    made = 0;
    while (made < n) begin
      if ($urandom_range(15) < 2) begin
        run = $urandom_range(3, 1);
        for (i = 0; i < run; i++) begin
          b = '{ACT_PRESS, AMP_W'($urandom), 1'b0, '0};
          pending_beats.push_back(b);
        end
      end else begin
        run = $urandom_range(80, 1);
        for (i = 0; i < run; i++) begin
          case ($urandom_range(7))
            0:       amp = '0;
            1:       amp = '1;
            default: amp = AMP_W'($urandom);
          endcase
          b = '{ACT_TICK, amp, 1'b0, '0};
          pending_beats.push_back(b);
        end
      end
      made += run;
    end
  endtask

  task automatic drain_all();
    while (pending_beats.size() != 0) @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  initial begin : main
    int unsigned r;
    int unsigned c;
    int unsigned p;
    in_beat_t b;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_TICK;
    in_ch.amplitude = '0;
    out_ch.ready    = 1'b0;

    // walk every period shape, the mode wrap and the sawtooth overflow
    directed_rows = '{
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd0,    MODE_SQUARE, 7'd0}},
      '{ACT_PRESS, 12'd0,    1,  1'b0, '0},
      '{ACT_TICK,  12'd4095, 23, 1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd4095, MODE_SQUARE, 7'd24}},
      '{ACT_TICK,  12'd0,    1,  1'b1, '{12'd0,    MODE_SQUARE, 7'd25}},
      '{ACT_TICK,  12'd2048, 13, 1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd0,    MODE_SINE,   7'd0}},
      '{ACT_PRESS, 12'd4095, 1,  1'b0, '0},
      '{ACT_TICK,  12'd4095, 11, 1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd3722, MODE_SINE,   7'd12}},
      '{ACT_TICK,  12'd4095, 12, 1'b0, '0},
      '{ACT_TICK,  12'd0,    1,  1'b1, '{12'd61,   MODE_SINE,   7'd25}},
      '{ACT_TICK,  12'd4095, 47, 1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd0,    MODE_SAW,    7'd0}},
      '{ACT_TICK,  12'd4095, 38, 1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd545,  MODE_SAW,    7'd39}},
      '{ACT_PRESS, 12'd0,    1,  1'b0, '0},
      '{ACT_PRESS, 12'd4095, 3,  1'b0, '0},
      '{ACT_TICK,  12'd4095, 1,  1'b1, '{12'd0,    MODE_SQUARE, 7'd0}},
      '{ACT_TICK,  12'd1365, 38, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_ROWS; r++) begin
      for (c = 0; c < directed_rows[r].count; c++) begin
        b = '{directed_rows[r].action, directed_rows[r].amplitude,
              directed_rows[r].typed, directed_rows[r].beat};
        pending_beats.push_back(b);
      end
    end
    drain_all();

    // random phases under different idle and stall mixes
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      queue_random_beats(RANDOM_BEATS / 4);
      drain_all();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("three_mode_waveform_generator: match");
    end else begin
      $display("three_mode_waveform_generator: mismatch");
    end
    $finish;
  end

endmodule
